>>> src/cri_pkg.sv
// Shared types and constants for the camera/recorder interface controller.
`timescale 1ns / 1ps

package cri_pkg;

  localparam int unsigned NumRegs   = 7;
  localparam int unsigned AddrWidth = 5;

  // Register indexes
  localparam logic [2:0] RegLowBatt   = 3'd0;
  localparam logic [2:0] RegCamOn     = 3'd1;
  localparam logic [2:0] RegPbHold    = 3'd2;
  localparam logic [2:0] RegRecWindow = 3'd3;
  localparam logic [2:0] RegRrHold    = 3'd4;
  localparam logic [2:0] RegCmdHold   = 3'd5;
  localparam logic [2:0] RegStartHold = 3'd6;

  // Register reset values
  localparam logic [7:0] LowBattRst   = 8'd80;
  localparam logic [7:0] CamOnRst     = 8'd16;
  localparam logic [7:0] PbHoldRst    = 8'd50;
  localparam logic [7:0] RecWindowRst = 8'd50;
  localparam logic [7:0] RrHoldRst    = 8'd50;
  localparam logic [7:0] CmdHoldRst   = 8'd50;
  localparam logic [7:0] StartHoldRst = 8'd250;

  // Divider chain
  localparam logic [3:0] FiftyWrap = 4'd10;
  localparam logic [4:0] BlinkOff  = 5'd5;
  localparam logic [4:0] BlinkWrap = 5'd25;

  // Consumption scaling: diff * 8, saturating once diff reaches 32
  localparam logic [7:0] PowerSat = 8'd255;

  typedef enum logic [1:0] {
    CMD_IDLE   = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_REVIEW = 2'd2,
    CMD_REC    = 2'd3
  } cri_cmd_t;

  typedef struct packed {
    logic [7:0] low_batt_level;
    logic [7:0] cam_on_level;
    logic [7:0] playback_hold;
    logic [7:0] rec_trigger_window;
    logic [7:0] review_hold;
    logic [7:0] command_hold;
    logic [7:0] startup_hold;
  } cri_cfg_t;

  typedef struct packed {
    logic       vtr_playback;
    logic       rec_button_low;
    logic       review_button_down;
    logic       link_up;
    logic [7:0] supply_level;
    logic [7:0] camera_level;
  } cri_in_t;

  typedef struct packed {
    logic       relay_on;
    logic       recorder_run;
    logic       recorder_standby;
    logic       camera_led;
    logic       camera_playback;
    logic [1:0] link_command;
    logic [7:0] camera_power;
    logic       low_battery;
    logic       camera_off;
  } cri_out_t;

endpackage

>>> src/cri_cfg.sv
// APB-style configuration register bank.
`timescale 1ns / 1ps

module cri_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cri_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output cri_pkg::cri_cfg_t             cfg
);
  import cri_pkg::*;

  cri_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] idx;
  logic [7:0] rd_val;

  assign idx   = paddr[AddrWidth-1:2];
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_batt_level     <= LowBattRst;
      cfg_r.cam_on_level       <= CamOnRst;
      cfg_r.playback_hold      <= PbHoldRst;
      cfg_r.rec_trigger_window <= RecWindowRst;
      cfg_r.review_hold        <= RrHoldRst;
      cfg_r.command_hold       <= CmdHoldRst;
      cfg_r.startup_hold       <= StartHoldRst;
    end else if (wr_en) begin
      unique case (idx)
        RegLowBatt:   cfg_r.low_batt_level     <= pwdata[7:0];
        RegCamOn:     cfg_r.cam_on_level       <= pwdata[7:0];
        RegPbHold:    cfg_r.playback_hold      <= pwdata[7:0];
        RegRecWindow: cfg_r.rec_trigger_window <= pwdata[7:0];
        RegRrHold:    cfg_r.review_hold        <= pwdata[7:0];
        RegCmdHold:   cfg_r.command_hold       <= pwdata[7:0];
        RegStartHold: cfg_r.startup_hold       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegLowBatt:   rd_val = cfg_r.low_batt_level;
      RegCamOn:     rd_val = cfg_r.cam_on_level;
      RegPbHold:    rd_val = cfg_r.playback_hold;
      RegRecWindow: rd_val = cfg_r.rec_trigger_window;
      RegRrHold:    rd_val = cfg_r.review_hold;
      RegCmdHold:   rd_val = cfg_r.command_hold;
      RegStartHold: rd_val = cfg_r.startup_hold;
      default:      rd_val = 8'd0;
    endcase
  end

  assign prdata = {24'd0, rd_val};
  assign cfg    = cfg_r;

endmodule

>>> src/cri_tick.sv
// Per-tick controller state and next-state logic.
`timescale 1ns / 1ps

module cri_tick (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  cri_pkg::cri_cfg_t cfg,
  input  cri_pkg::cri_in_t  tin,
  output cri_pkg::cri_out_t tout
);
  import cri_pkg::*;

  logic       half_r,    half_nxt;
  logic [3:0] fifty_r,   fifty_nxt;
  logic [4:0] blink_r,   blink_nxt;
  logic       slow_r,    slow_nxt;
  logic [7:0] start_r,   start_nxt;
  logic [7:0] pbcnt_r,   pbcnt_nxt;
  logic [7:0] recwin_r,  recwin_nxt;
  logic [7:0] rrcnt_r,   rrcnt_nxt;
  logic [7:0] cmdcnt_r,  cmdcnt_nxt;
  cri_cmd_t   cmd_r,     cmd_nxt;
  logic       fpb_r,     fpb_nxt;
  logic       frec_r,    frec_nxt;
  logic       frr_r,     frr_nxt;
  logic       lock_r,    lock_nxt;
  logic       camoff_r,  camoff_nxt;

  logic       tick2;
  logic       lowb;
  logic [7:0] diff;
  logic [7:0] power;
  logic       rly, run, led, campb;

  always_comb begin
    half_nxt   = ~half_r;
    fifty_nxt  = fifty_r;
    blink_nxt  = blink_r;
    slow_nxt   = slow_r;
    start_nxt  = start_r;
    pbcnt_nxt  = pbcnt_r;
    recwin_nxt = recwin_r;
    rrcnt_nxt  = rrcnt_r;
    cmdcnt_nxt = cmdcnt_r;
    cmd_nxt    = cmd_r;
    fpb_nxt    = fpb_r;
    frec_nxt   = frec_r;
    frr_nxt    = frr_r;
    lock_nxt   = lock_r;
    camoff_nxt = camoff_r;
    tick2      = half_r;
    diff       = tin.supply_level - tin.camera_level;
    power      = 8'd0;

    // divider chain
    if (half_r) begin
      fifty_nxt = fifty_r + 4'd1;
      if (fifty_nxt >= FiftyWrap) begin
        fifty_nxt = 4'd0;
        blink_nxt = blink_r + 5'd1;
        if (blink_nxt >= BlinkOff) slow_nxt = 1'b0;
        if (blink_nxt >= BlinkWrap) begin
          blink_nxt = 5'd0;
          slow_nxt  = 1'b1;
        end
      end
    end

    // supply checks
    lowb = (tin.supply_level != 8'd0) && (tin.supply_level < cfg.low_batt_level);
    if ((tin.supply_level != 8'd0) && (tin.camera_level != 8'd0) &&
        (tin.supply_level >= tin.camera_level)) begin
      power      = (diff[7:5] == 3'd0) ? {diff[4:0], 3'b000} : PowerSat;
      camoff_nxt = power < cfg.cam_on_level;
    end

    // input filtering
    if (start_r == 8'd0) begin
      if ((tin.vtr_playback != fpb_r) && (pbcnt_r == 8'd0)) begin
        fpb_nxt   = tin.vtr_playback;
        pbcnt_nxt = cfg.playback_hold;
      end
      if (tin.rec_button_low) begin
        if (!frec_r) begin
          frec_nxt   = 1'b1;
          recwin_nxt = cfg.rec_trigger_window;
          lock_nxt   = ~lock_r;
        end
      end else if (frec_r) begin
        frec_nxt = 1'b0;
        if (recwin_r == 8'd0) lock_nxt = 1'b0;
      end
      if (!lock_nxt) begin
        if ((tin.review_button_down != frr_r) && (rrcnt_r == 8'd0)) begin
          frr_nxt   = tin.review_button_down;
          rrcnt_nxt = cfg.review_hold;
        end
      end else begin
        frr_nxt = 1'b0;
      end
    end

    // outputs
    if (frr_nxt && tin.link_up) begin
      cmd_nxt    = CMD_REVIEW;
      cmdcnt_nxt = cfg.command_hold;
    end
    rly   = fpb_nxt;
    campb = fpb_nxt;
    if (fpb_nxt) lock_nxt = 1'b0;
    if (lock_nxt) begin
      run = 1'b1;
      led = !(lowb && slow_nxt);
      if (tin.link_up) begin
        cmd_nxt    = CMD_REC;
        cmdcnt_nxt = cfg.command_hold;
      end
    end else begin
      run = 1'b0;
      led = lowb && slow_nxt;
    end
    if (camoff_nxt) begin
      lock_nxt = 1'b0;
      rly      = 1'b0;
      run      = 1'b0;
      led      = 1'b0;
      campb    = 1'b0;
    end

    // 2 ms countdowns
    if (tick2) begin
      if (start_nxt  != 8'd0) start_nxt  = start_nxt  - 8'd1;
      if (pbcnt_nxt  != 8'd0) pbcnt_nxt  = pbcnt_nxt  - 8'd1;
      if (recwin_nxt != 8'd0) recwin_nxt = recwin_nxt - 8'd1;
      if (rrcnt_nxt  != 8'd0) rrcnt_nxt  = rrcnt_nxt  - 8'd1;
      if (cmdcnt_nxt != 8'd0) cmdcnt_nxt = cmdcnt_nxt - 8'd1;
      else cmd_nxt = CMD_IDLE;
    end

    tout.relay_on         = rly;
    tout.recorder_run     = run;
    tout.recorder_standby = camoff_nxt;
    tout.camera_led       = led;
    tout.camera_playback  = campb;
    tout.link_command     = cmd_nxt;
    tout.camera_power     = power;
    tout.low_battery      = lowb;
    tout.camera_off       = camoff_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r   <= 1'b0;
      fifty_r  <= 4'd0;
      blink_r  <= 5'd0;
      slow_r   <= 1'b0;
      start_r  <= StartHoldRst;
      pbcnt_r  <= 8'd0;
      recwin_r <= 8'd0;
      rrcnt_r  <= 8'd0;
      cmdcnt_r <= CmdHoldRst;
      cmd_r    <= CMD_STOP;
      fpb_r    <= 1'b0;
      frec_r   <= 1'b0;
      frr_r    <= 1'b0;
      lock_r   <= 1'b0;
      camoff_r <= 1'b0;
    end else if (step) begin
      half_r   <= half_nxt;
      fifty_r  <= fifty_nxt;
      blink_r  <= blink_nxt;
      slow_r   <= slow_nxt;
      start_r  <= start_nxt;
      pbcnt_r  <= pbcnt_nxt;
      recwin_r <= recwin_nxt;
      rrcnt_r  <= rrcnt_nxt;
      cmdcnt_r <= cmdcnt_nxt;
      cmd_r    <= cmd_nxt;
      fpb_r    <= fpb_nxt;
      frec_r   <= frec_nxt;
      frr_r    <= frr_nxt;
      lock_r   <= lock_nxt;
      camoff_r <= camoff_nxt;
    end
  end

endmodule

>>> src/camera_recorder_interface_controller.sv
// Camera/recorder interface controller: 1 ms tick in, pin drives and link command out.
`timescale 1ns / 1ps

// Each input transaction is one 1 ms tick. It is captured in an input register,
// the controller state is advanced by one pass of logic once the output side
// can take a result, and the result lands in an output register. One tick is
// taken every clock while the output side keeps up. All hold and window
// registers count in 2 ms units (every second tick). The registers are written
// through the APB-style port and should only change while no tick is in flight.
module camera_recorder_interface_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_vtr_playback,
  input  logic        in_rec_button_low,
  input  logic        in_review_button_down,
  input  logic        in_link_up,
  input  logic [7:0]  in_supply_level,
  input  logic [7:0]  in_camera_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_relay_on,
  output logic        out_recorder_run,
  output logic        out_recorder_standby,
  output logic        out_camera_led,
  output logic        out_camera_playback,
  output logic [1:0]  out_link_command,
  output logic [7:0]  out_camera_power,
  output logic        out_low_battery,
  output logic        out_camera_off,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cri_pkg::*;

  cri_cfg_t cfg;
  cri_in_t  in_r;
  logic     in_valid_r;
  cri_out_t tick_out;
  cri_out_t out_r;
  logic     out_valid_r;
  logic     step;

  assign pready   = 1'b1;
  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  cri_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  cri_tick u_tick (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cfg   (cfg),
    .tin   (in_r),
    .tout  (tick_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) in_valid_r <= 1'b1;
      else if (step)            in_valid_r <= 1'b0;
      if (step)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r.vtr_playback       <= in_vtr_playback;
      in_r.rec_button_low     <= in_rec_button_low;
      in_r.review_button_down <= in_review_button_down;
      in_r.link_up            <= in_link_up;
      in_r.supply_level       <= in_supply_level;
      in_r.camera_level       <= in_camera_level;
    end
    if (step) out_r <= tick_out;
  end

  assign out_valid            = out_valid_r;
  assign out_relay_on         = out_r.relay_on;
  assign out_recorder_run     = out_r.recorder_run;
  assign out_recorder_standby = out_r.recorder_standby;
  assign out_camera_led       = out_r.camera_led;
  assign out_camera_playback  = out_r.camera_playback;
  assign out_link_command     = out_r.link_command;
  assign out_camera_power     = out_r.camera_power;
  assign out_low_battery      = out_r.low_battery;
  assign out_camera_off       = out_r.camera_off;

`ifndef SYNTHESIS
  a_standby_tracks_camoff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.recorder_standby == out_r.camera_off))
    else $error("standby does not follow camera off");

  a_camoff_forces_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.camera_off) |->
      (!out_r.relay_on && !out_r.recorder_run && !out_r.camera_led &&
       !out_r.camera_playback))
    else $error("camera off but drives active");

  a_playback_excludes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.relay_on) |->
      (out_r.camera_playback && !out_r.recorder_run))
    else $error("playback relay with record run");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_ready) |=> in_valid_r)
    else $error("input stage dropped a tick under stall");
`endif

endmodule

>>> verif/cri_tick_checker.sv
// Checker for the camera/recorder interface controller: predicts each tick and compares.
`timescale 1ns / 1ps

module cri_tick_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_vtr_playback,
  input  logic        in_rec_button_low,
  input  logic        in_review_button_down,
  input  logic        in_link_up,
  input  logic [7:0]  in_supply_level,
  input  logic [7:0]  in_camera_level,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_relay_on,
  input  logic        out_recorder_run,
  input  logic        out_recorder_standby,
  input  logic        out_camera_led,
  input  logic        out_camera_playback,
  input  logic [1:0]  out_link_command,
  input  logic [7:0]  out_camera_power,
  input  logic        out_low_battery,
  input  logic        out_camera_off,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [cri_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fault_count,
  output int          pending
);
  import cri_pkg::*;

  cri_cfg_t cfg;
  cri_out_t expected_drives[$];
  int       results_seen;

  // controller state copy
  logic       half_tick;
  logic [3:0] ms20_div;
  logic [4:0] blink_div;
  logic       blink_on;
  logic [7:0] startup_left, pb_left, recwin_left, rr_left, cmd_left;
  cri_cmd_t   cur_cmd;
  logic       f_pb, f_rec, f_rr;
  logic       rec_lock, low_batt, cam_off;
  logic       drv_relay, drv_run, drv_stby, drv_led, drv_campb;
  logic [7:0] power_est;

  initial begin
    fault_count  = 0;
    pending      = 0;
    results_seen = 0;
  end

  task automatic report_fault(input string what);
    fault_count = fault_count + 1;
    $display("%0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_fault($sformatf("result %0d %s: got %0d, expected %0d",
                             results_seen, name, got, want));
  endtask

  task automatic advance_tick(input cri_in_t t, output cri_out_t r);
    logic       two_ms;
    logic [7:0] diff;
    two_ms = half_tick;
    half_tick = ~half_tick;
    if (two_ms) begin
      ms20_div = ms20_div + 4'd1;
      if (ms20_div >= FiftyWrap) begin
        ms20_div = '0;
        blink_div = blink_div + 5'd1;
        if (blink_div >= BlinkOff) blink_on = 1'b0;
        if (blink_div >= BlinkWrap) begin
          blink_div = '0;
          blink_on = 1'b1;
        end
      end
    end

    low_batt = (t.supply_level != 0) && (t.supply_level < cfg.low_batt_level);
    power_est = '0;
    if (t.supply_level != 0 && t.camera_level != 0 && t.supply_level >= t.camera_level) begin
      diff = t.supply_level - t.camera_level;
      power_est = (diff[7:5] == 3'd0) ? {diff[4:0], 3'b000} : PowerSat;
      cam_off = power_est < cfg.cam_on_level;
    end

    if (startup_left == 0) begin
      if (t.vtr_playback != f_pb && pb_left == 0) begin
        f_pb = t.vtr_playback;
        pb_left = cfg.playback_hold;
      end
      if (t.rec_button_low) begin
        if (!f_rec) begin
          f_rec = 1'b1;
          recwin_left = cfg.rec_trigger_window;
          rec_lock = ~rec_lock;
        end
      end else if (f_rec) begin
        f_rec = 1'b0;
        if (recwin_left == 0) rec_lock = 1'b0;
      end
      if (!rec_lock) begin
        if (t.review_button_down != f_rr && rr_left == 0) begin
          f_rr = t.review_button_down;
          rr_left = cfg.review_hold;
        end
      end else begin
        f_rr = 1'b0;
      end
    end

    if (f_rr && t.link_up) begin
      cur_cmd = CMD_REVIEW;
      cmd_left = cfg.command_hold;
    end
    if (f_pb) begin
      drv_run = 1'b0;
      drv_stby = 1'b0;
      drv_relay = 1'b1;
      drv_campb = 1'b1;
      rec_lock = 1'b0;
    end else begin
      drv_relay = 1'b0;
      drv_campb = 1'b0;
    end
    if (rec_lock) begin
      drv_led = 1'b1;
      drv_run = 1'b1;
      if (t.link_up) begin
        cur_cmd = CMD_REC;
        cmd_left = cfg.command_hold;
      end
      if (low_batt && blink_on) drv_led = 1'b0;
    end else begin
      drv_led = 1'b0;
      drv_run = 1'b0;
      if (low_batt && blink_on) drv_led = 1'b1;
    end
    if (cam_off) begin
      rec_lock = 1'b0;
      drv_relay = 1'b0;
      drv_run = 1'b0;
      drv_led = 1'b0;
      drv_campb = 1'b0;
      drv_stby = 1'b1;
    end else begin
      drv_stby = 1'b0;
    end

    if (two_ms) begin
      if (startup_left != 0) startup_left = startup_left - 8'd1;
      if (pb_left != 0) pb_left = pb_left - 8'd1;
      if (recwin_left != 0) recwin_left = recwin_left - 8'd1;
      if (rr_left != 0) rr_left = rr_left - 8'd1;
      if (cmd_left != 0) cmd_left = cmd_left - 8'd1;
      else cur_cmd = CMD_IDLE;
    end

    r.relay_on         = drv_relay;
    r.recorder_run     = drv_run;
    r.recorder_standby = drv_stby;
    r.camera_led       = drv_led;
    r.camera_playback  = drv_campb;
    r.link_command     = cur_cmd;
    r.camera_power     = power_est;
    r.low_battery      = low_batt;
    r.camera_off       = cam_off;
  endtask

  always @(posedge clk) begin
    cri_in_t  tk;
    cri_out_t want;
    if (!rst_n) begin
      cfg.low_batt_level     = LowBattRst;
      cfg.cam_on_level       = CamOnRst;
      cfg.playback_hold      = PbHoldRst;
      cfg.rec_trigger_window = RecWindowRst;
      cfg.review_hold        = RrHoldRst;
      cfg.command_hold       = CmdHoldRst;
      cfg.startup_hold       = StartHoldRst;
      half_tick    = 1'b0;
      ms20_div     = '0;
      blink_div    = '0;
      blink_on     = 1'b0;
      startup_left = StartHoldRst;
      pb_left      = '0;
      recwin_left  = '0;
      rr_left      = '0;
      cmd_left     = CmdHoldRst;
      cur_cmd      = CMD_STOP;
      {f_pb, f_rec, f_rr} = '0;
      {rec_lock, low_batt, cam_off} = '0;
      {drv_relay, drv_run, drv_stby, drv_led, drv_campb} = '0;
      power_est    = '0;
      expected_drives.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrWidth-1:2])
          RegLowBatt:   cfg.low_batt_level     = pwdata[7:0];
          RegCamOn:     cfg.cam_on_level       = pwdata[7:0];
          RegPbHold:    cfg.playback_hold      = pwdata[7:0];
          RegRecWindow: cfg.rec_trigger_window = pwdata[7:0];
          RegRrHold:    cfg.review_hold        = pwdata[7:0];
          RegCmdHold:   cfg.command_hold       = pwdata[7:0];
          RegStartHold: cfg.startup_hold       = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_drives.size() == 0) begin
          report_fault("result transaction with no tick outstanding");
        end else begin
          want = expected_drives.pop_front();
          check_field("relay_on", out_relay_on, want.relay_on);
          check_field("recorder_run", out_recorder_run, want.recorder_run);
          check_field("recorder_standby", out_recorder_standby, want.recorder_standby);
          check_field("camera_led", out_camera_led, want.camera_led);
          check_field("camera_playback", out_camera_playback, want.camera_playback);
          check_field("link_command", out_link_command, want.link_command);
          check_field("camera_power", out_camera_power, want.camera_power);
          check_field("low_battery", out_low_battery, want.low_battery);
          check_field("camera_off", out_camera_off, want.camera_off);
        end
        results_seen = results_seen + 1;
      end
      if (in_valid && in_ready) begin
        tk = '{vtr_playback: in_vtr_playback, rec_button_low: in_rec_button_low,
               review_button_down: in_review_button_down, link_up: in_link_up,
               supply_level: in_supply_level, camera_level: in_camera_level};
        advance_tick(tk, want);
        expected_drives.push_back(want);
      end
    end
    pending <= expected_drives.size();
  end

endmodule

>>> verif/tb_camera_recorder_interface_controller.sv
// Testbench top for the camera/recorder interface controller: stimulus and verdict.
`timescale 1ns / 1ps

module tb_camera_recorder_interface_controller;
  import cri_pkg::*;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam int CycleLimit = 200000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_vtr_playback = 1'b0;
  logic        in_rec_button_low = 1'b0;
  logic        in_review_button_down = 1'b0;
  logic        in_link_up = 1'b0;
  logic [7:0]  in_supply_level = '0;
  logic [7:0]  in_camera_level = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_relay_on, out_recorder_run, out_recorder_standby;
  logic        out_camera_led, out_camera_playback;
  logic [1:0]  out_link_command;
  logic [7:0]  out_camera_power;
  logic        out_low_battery, out_camera_off;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fault_count;
  int pending;
  int cycle_count = 0;
  int burst_left = 0;
  int run_left = 0;
  int stall_left = 0;
  cri_in_t held = '0;

  camera_recorder_interface_controller uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vtr_playback(in_vtr_playback), .in_rec_button_low(in_rec_button_low),
    .in_review_button_down(in_review_button_down), .in_link_up(in_link_up),
    .in_supply_level(in_supply_level), .in_camera_level(in_camera_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_relay_on(out_relay_on), .out_recorder_run(out_recorder_run),
    .out_recorder_standby(out_recorder_standby), .out_camera_led(out_camera_led),
    .out_camera_playback(out_camera_playback), .out_link_command(out_link_command),
    .out_camera_power(out_camera_power), .out_low_battery(out_low_battery),
    .out_camera_off(out_camera_off),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cri_tick_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vtr_playback(in_vtr_playback), .in_rec_button_low(in_rec_button_low),
    .in_review_button_down(in_review_button_down), .in_link_up(in_link_up),
    .in_supply_level(in_supply_level), .in_camera_level(in_camera_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_relay_on(out_relay_on), .out_recorder_run(out_recorder_run),
    .out_recorder_standby(out_recorder_standby), .out_camera_led(out_camera_led),
    .out_camera_playback(out_camera_playback), .out_link_command(out_link_command),
    .out_camera_power(out_camera_power), .out_low_battery(out_low_battery),
    .out_camera_off(out_camera_off),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fault_count(fault_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: ready runs broken by short stalls, sometimes none
  always @(negedge clk) begin
    if (run_left > 0) begin
      out_ready <= 1'b1;
      run_left <= run_left - 1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 1) == 1);
      run_left <= $urandom_range(0, 30);
      stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
    end
  end

  function automatic cri_in_t tick_of(input logic pb, input logic rec, input logic rr,
                                      input logic link, input logic [7:0] supply,
                                      input logic [7:0] cam);
    cri_in_t t;
    t.vtr_playback       = pb;
    t.rec_button_low     = rec;
    t.review_button_down = rr;
    t.link_up            = link;
    t.supply_level       = supply;
    t.camera_level       = cam;
    return t;
  endfunction

  task automatic send_tick(input cri_in_t t);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_valid              <= 1'b1;
    in_vtr_playback       <= t.vtr_playback;
    in_rec_button_low     <= t.rec_button_low;
    in_review_button_down <= t.review_button_down;
    in_link_up            <= t.link_up;
    in_supply_level       <= t.supply_level;
    in_camera_level       <= t.camera_level;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // hold input traffic until every predicted result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] value);
    logic [23:0] junk;
    junk = 24'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [7:0] lb, input logic [7:0] con,
                              input logic [7:0] pbh, input logic [7:0] rw,
                              input logic [7:0] rrh, input logic [7:0] ch,
                              input logic [7:0] sh);
    cfg_write(RegLowBatt, lb);
    cfg_write(RegCamOn, con);
    cfg_write(RegPbHold, pbh);
    cfg_write(RegRecWindow, rw);
    cfg_write(RegRrHold, rrh);
    cfg_write(RegCmdHold, ch);
    cfg_write(RegStartHold, sh);
    cfg_write(RegUnused, 8'($urandom));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // pins behave like held buttons and switches, with occasional glitch ticks
  task automatic roll_tick(output cri_in_t t);
    int unsigned diff;
    if ($urandom_range(0, 11) == 0) held.vtr_playback = ~held.vtr_playback;
    if ($urandom_range(0, 5) == 0) held.rec_button_low = ~held.rec_button_low;
    if ($urandom_range(0, 9) == 0) held.review_button_down = ~held.review_button_down;
    if ($urandom_range(0, 24) == 0) held.link_up = ~held.link_up;
    t = held;
    if ($urandom_range(0, 9) == 0) begin
      t.vtr_playback       = 1'($urandom);
      t.rec_button_low     = 1'($urandom);
      t.review_button_down = 1'($urandom);
      t.link_up            = 1'($urandom);
    end
    if ($urandom_range(0, 6) != 0) begin
      t.supply_level = 8'($urandom_range(40, 255));
      diff = $urandom_range(0, 40);
      t.camera_level = t.supply_level - 8'(diff);
    end else begin
      t.supply_level = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      t.camera_level = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    end
  endtask

  task automatic random_ticks(input int n);
    cri_in_t t;
    repeat (n) begin
      roll_tick(t);
      send_tick(t);
    end
  endtask

  initial begin
    cri_in_t startup_ticks[$];
    cri_in_t pin_ticks[$];

    // supply and camera corners, pins ignored while startup hold runs
    startup_ticks = '{tick_of(0, 0, 0, 0, 0, 0),     tick_of(1, 1, 1, 1, 0, 100),
                      tick_of(0, 0, 0, 0, 100, 0),   tick_of(1, 1, 1, 1, 100, 100),
                      tick_of(0, 0, 0, 1, 100, 99),  tick_of(1, 0, 1, 0, 131, 100),
                      tick_of(0, 1, 0, 1, 132, 100), tick_of(1, 1, 1, 0, 255, 1),
                      tick_of(0, 0, 1, 1, 50, 60),   tick_of(1, 0, 0, 0, 79, 0),
                      tick_of(0, 1, 1, 1, 80, 70),   tick_of(1, 1, 0, 0, 1, 1),
                      tick_of(0, 0, 0, 0, 255, 255)};
    // pin behavior with zero holds: playback, lock toggle, review, link down,
    // camera off, low battery with lock, unmeasured supply
    pin_ticks = '{tick_of(1, 0, 0, 1, 200, 190), tick_of(0, 0, 0, 1, 200, 190),
                  tick_of(0, 1, 0, 1, 200, 190), tick_of(0, 1, 1, 1, 200, 190),
                  tick_of(0, 0, 0, 1, 200, 190), tick_of(0, 0, 1, 1, 200, 190),
                  tick_of(0, 0, 1, 0, 200, 190), tick_of(0, 0, 0, 0, 200, 190),
                  tick_of(0, 1, 0, 1, 200, 200), tick_of(0, 0, 0, 1, 60, 50),
                  tick_of(0, 1, 0, 1, 60, 50),   tick_of(1, 1, 0, 1, 0, 0)};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (startup_ticks[i]) send_tick(startup_ticks[i]);
    settle();
    program_regs(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    random_ticks(236);
    settle();
    program_regs(8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    random_ticks(252);
    settle();

    program_regs(8'd80, 8'd16, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    foreach (pin_ticks[i]) send_tick(pin_ticks[i]);
    settle();

    program_regs(8'd100, 8'd16, 8'd2, 8'd3, 8'd2, 8'd1, 8'd9);
    random_ticks(16);
    settle();
    program_regs(LowBattRst, CamOnRst, PbHoldRst, RecWindowRst, RrHoldRst, CmdHoldRst,
                 StartHoldRst);
    random_ticks(6);
    settle();
    program_regs(8'd120, 8'd40, 8'd0, 8'd10, 8'd5, 8'd0, 8'd0);
    random_ticks(10);
    settle();
    program_regs(8'd200, 8'd8, 8'd255, 8'd255, 8'd255, 8'd255, 8'd128);
    random_ticks(4);
    settle();
    program_regs(8'($urandom), 8'($urandom_range(0, 64)), 8'($urandom_range(0, 8)),
                 8'($urandom_range(0, 20)), 8'($urandom_range(0, 8)),
                 8'($urandom_range(0, 10)), 8'($urandom));
    random_ticks(10);
    settle();

    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/cri_pkg.sv
src/cri_cfg.sv
src/cri_tick.sv
src/camera_recorder_interface_controller.sv
verif/cri_tick_checker.sv
verif/tb_camera_recorder_interface_controller.sv
